@@ design/mkd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkd_pkg: shared definitions for the Morse keying decoder
// Field widths, default sizes, symbol codes and queue command codes.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // default sizes for the top level parameters
  localparam int MAX_MARKS_DEF   = 8;
  localparam int LENGTH_BITS_DEF = 16;

  // fixed field widths
  localparam int TIME_W   = 32;
  localparam int CODE_W   = 32;
  localparam int TOTAL_W  = 4;
  localparam int WEIGHT_W = 4;
  localparam int SYM_W    = 4;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd4;

  // command queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // one symbol of the packed letter code
  typedef logic [SYM_W-1:0] sym_t;

  localparam sym_t SYM_DIT = 4'd1;
  localparam sym_t SYM_DAH = 4'd2;

  // command kinds carried by the queue
  localparam logic CMD_MARK = 1'b0;
  localparam logic CMD_END  = 1'b1;

endpackage

@@ design/mkd_queue.sv @@
// ----------------------------------------------------------------------------
// mkd_queue: command queue between front and back
// Small first-in first-out buffer; the head entry is shown while not empty.
// ----------------------------------------------------------------------------
module mkd_queue #(
  parameter int DATA_W = 18,
  parameter int DEPTH  = mkd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);
  import mkd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [AW:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]       fill;

  assign fill       = wr_ptr_r - rd_ptr_r;
  assign full       = (fill == (AW + 1)'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = slot_r[rd_ptr_r[AW-1:0]];

  // pointer update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r[AW-1:0] == AW'(DEPTH - 1)) ?
                   {~wr_ptr_r[AW], {AW{1'b0}}} : wr_ptr_r + 1'b1;
    end
    if (pop && head_valid) begin
      rd_ptr_nxt = (rd_ptr_r[AW-1:0] == AW'(DEPTH - 1)) ?
                   {~rd_ptr_r[AW], {AW{1'b0}}} : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r[AW-1:0]] <= push_data;
    end
  end

endmodule

@@ design/mkd_front.sv @@
// ----------------------------------------------------------------------------
// mkd_front: edge timing front end
// Accepts key edge beats, measures marks and gaps, and queues mark and
// letter-end commands for the back end.
// ----------------------------------------------------------------------------
module mkd_front #(
  parameter int MAX_MARKS   = mkd_pkg::MAX_MARKS_DEF,
  parameter int LENGTH_BITS = mkd_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mkd_pkg::TIME_W-1:0]    in_edge_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mkd_pkg::WEIGHT_W-1:0]  cfg_data,
  output logic                          push,
  output logic [LENGTH_BITS+1:0]        push_data,
  input  logic                          full
);
  import mkd_pkg::*;

  localparam int CW    = $clog2(MAX_MARKS + 1);
  localparam int LIM_W = LENGTH_BITS + WEIGHT_W;
  localparam int CMP_W = TIME_W + LIM_W;
  localparam logic [TIME_W:0] LEN_MAX_W =
    ({{TIME_W{1'b0}}, 1'b1} << LENGTH_BITS) - 1'b1;

  logic                   expect_release_r, expect_release_nxt;
  logic [TIME_W-1:0]      prev_edge_r, prev_edge_nxt;
  logic [LENGTH_BITS-1:0] shortest_r, shortest_nxt;
  logic [CW-1:0]          held_r, held_nxt;
  logic [LENGTH_BITS-1:0] first_gap_r, first_gap_nxt;
  logic [1:0]             edges_r, edges_nxt;
  logic [WEIGHT_W-1:0]    weight_r;

  logic                   accept;
  logic [TIME_W-1:0]      delta;
  logic [LENGTH_BITS-1:0] sat_len;
  logic [LIM_W-1:0]       limit;
  logic                   gap_end;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // time since the previous edge, saturated to a mark length
  assign delta   = in_edge_time - prev_edge_r;
  assign sat_len = ({1'b0, delta} > LEN_MAX_W) ? {LENGTH_BITS{1'b1}}
                                                : delta[LENGTH_BITS-1:0];

  // letter gap limit and compare on the full difference
  assign limit   = {{WEIGHT_W{1'b0}}, shortest_r} * {{LENGTH_BITS{1'b0}}, weight_r};
  assign gap_end = (held_r != '0) &&
                   ({{LIM_W{1'b0}}, delta} > {{TIME_W{1'b0}}, limit});

  // edge classification
  always_comb begin
    expect_release_nxt = expect_release_r;
    prev_edge_nxt      = prev_edge_r;
    shortest_nxt       = shortest_r;
    held_nxt           = held_r;
    first_gap_nxt      = first_gap_r;
    edges_nxt          = edges_r;
    push               = 1'b0;
    push_data          = '0;
    if (accept) begin
      if (expect_release_r) begin
        // release: a mark ends
        push      = 1'b1;
        push_data = {CMD_MARK, 1'b0, sat_len};
        if (sat_len < shortest_r) begin
          shortest_nxt = sat_len;
        end
        if (held_r < CW'(MAX_MARKS)) begin
          held_nxt = held_r + 1'b1;
        end
        expect_release_nxt = 1'b0;
      end else begin
        // press: a long gap closes the letter
        if (gap_end) begin
          push      = 1'b1;
          push_data = {CMD_END, (edges_r == 2'd3), first_gap_r};
          held_nxt  = '0;
        end
        if (edges_r == 2'd2) begin
          first_gap_nxt = sat_len;
        end
        expect_release_nxt = 1'b1;
      end
      if (edges_r != 2'd3) begin
        edges_nxt = edges_r + 1'b1;
      end
      prev_edge_nxt = in_edge_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_release_r <= 1'b0;
      prev_edge_r      <= '0;
      shortest_r       <= {LENGTH_BITS{1'b1}};
      held_r           <= '0;
      first_gap_r      <= '0;
      edges_r          <= '0;
    end else begin
      expect_release_r <= expect_release_nxt;
      prev_edge_r      <= prev_edge_nxt;
      shortest_r       <= shortest_nxt;
      held_r           <= held_nxt;
      first_gap_r      <= first_gap_nxt;
      edges_r          <= edges_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      weight_r <= cfg_data;
    end
  end

endmodule

@@ design/mkd_back.sv @@
// ----------------------------------------------------------------------------
// mkd_back: letter builder back end
// Buffers marks, and on a letter end walks the buffer twice: once for the
// min and max, once to pack dit/dah symbols. Holds the result until taken.
// ----------------------------------------------------------------------------
module mkd_back #(
  parameter int MAX_MARKS   = mkd_pkg::MAX_MARKS_DEF,
  parameter int LENGTH_BITS = mkd_pkg::LENGTH_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [LENGTH_BITS+1:0]       q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mkd_pkg::CODE_W-1:0]   out_letter_code,
  output logic [mkd_pkg::TOTAL_W-1:0]  out_mark_total,
  output logic                         out_too_long
);
  import mkd_pkg::*;

  localparam int CW = $clog2(MAX_MARKS + 1);
  localparam int IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int LB = LENGTH_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_THR  = 3'd2;
  localparam logic [2:0] ST_PACK = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [1:0] MODE_MID = 2'd0;
  localparam logic [1:0] MODE_DIT = 2'd1;
  localparam logic [1:0] MODE_DAH = 2'd2;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     held_r, held_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [LB-1:0]     rd_r;
  logic [LB-1:0]     lo_r, lo_nxt;
  logic [LB-1:0]     hi_r, hi_nxt;
  logic [LB-1:0]     thr_r, thr_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [LB-1:0]     kd_r, kd_nxt;
  logic              kd_vld_r, kd_vld_nxt;
  logic [LB-1:0]     fg_r, fg_nxt;
  logic              fgk_r, fgk_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [LB-1:0]     store_r [MAX_MARKS];

  logic              mark_wr;
  logic              rd_en;
  sym_t              sym;
  logic [CW+TOTAL_W-1:0] held_ext;

  assign q_pop = (state_r == ST_IDLE) && q_valid;
  assign rd_en = ((state_r == ST_SCAN) || (state_r == ST_PACK)) && (idx_r < held_r);

  // symbol of the mark read last cycle
  always_comb begin
    case (mode_r)
      MODE_MID: sym = (rd_r > thr_r) ? SYM_DAH : SYM_DIT;
      MODE_DIT: sym = SYM_DIT;
      default:  sym = SYM_DAH;
    endcase
  end

  // letter sequencer
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    ovf_nxt    = ovf_r;
    idx_nxt    = idx_r;
    rd_vld_nxt = 1'b0;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    thr_nxt    = thr_r;
    mode_nxt   = mode_r;
    kd_nxt     = kd_r;
    kd_vld_nxt = kd_vld_r;
    fg_nxt     = fg_r;
    fgk_nxt    = fgk_r;
    code_nxt   = code_r;
    mark_wr    = 1'b0;
    if (rd_en) begin
      idx_nxt    = idx_r + 1'b1;
      rd_vld_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_data[LB+1] == CMD_MARK) begin
            if (held_r < CW'(MAX_MARKS)) begin
              mark_wr  = 1'b1;
              held_nxt = held_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            fg_nxt    = q_data[LB-1:0];
            fgk_nxt   = q_data[LB];
            idx_nxt   = '0;
            lo_nxt    = {LB{1'b1}};
            hi_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          if (rd_r < lo_r) lo_nxt = rd_r;
          if (rd_r > hi_r) hi_nxt = rd_r;
        end
        if (!rd_en && !rd_vld_r) begin
          state_nxt = ST_THR;
        end
      end
      ST_THR: begin
        if ({1'b0, hi_r} > {lo_r, 1'b0}) begin
          kd_nxt     = lo_r;
          kd_vld_nxt = 1'b1;
          mode_nxt   = MODE_MID;
          thr_nxt    = lo_r + ((hi_r - lo_r) >> 1);
        end else if (kd_vld_r) begin
          mode_nxt = ({1'b0, hi_r} < {kd_r, 1'b0}) ? MODE_DIT : MODE_DAH;
        end else if (fgk_r) begin
          mode_nxt = (hi_r < (fg_r >> 1)) ? MODE_DIT : MODE_DAH;
        end else begin
          mode_nxt = MODE_DAH;
        end
        idx_nxt   = '0;
        code_nxt  = '0;
        state_nxt = ST_PACK;
      end
      ST_PACK: begin
        if (rd_vld_r) begin
          code_nxt = {code_r[CODE_W-SYM_W-1:0], sym};
        end
        if (!rd_en && !rd_vld_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          held_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      ovf_r    <= 1'b0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      kd_r     <= '0;
      kd_vld_r <= 1'b0;
      fg_r     <= '0;
      fgk_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      ovf_r    <= ovf_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= rd_vld_nxt;
      kd_r     <= kd_nxt;
      kd_vld_r <= kd_vld_nxt;
      fg_r     <= fg_nxt;
      fgk_r    <= fgk_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    thr_r  <= thr_nxt;
    mode_r <= mode_nxt;
    code_r <= code_nxt;
  end

  // mark buffer, registered read
  always_ff @(posedge clk) begin
    if (mark_wr) begin
      store_r[held_r[IW-1:0]] <= q_data[LB-1:0];
    end
    rd_r <= store_r[idx_r[IW-1:0]];
  end

  // result beat
  assign held_ext        = {{TOTAL_W{1'b0}}, held_r};
  assign out_valid       = (state_r == ST_OUT);
  assign out_letter_code = code_r;
  assign out_mark_total  = held_ext[TOTAL_W-1:0];
  assign out_too_long    = ovf_r;

endmodule

@@ design/morse_keying_decoder.sv @@
// ----------------------------------------------------------------------------
// morse_keying_decoder: adaptive Morse keying timing decoder
// Turns key edge timestamps into nibble-packed dit/dah letter codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per key edge timestamp; presses and releases alternate,
//           starting with a press. Edges are taken one per cycle while the
//           four-entry command queue has room; in_stall rises when it is full.
//   out_* : one beat per finished letter, produced when a press follows a long
//           gap. The beat is held stable while out_stall is high, and the
//           front keeps taking edges into the queue meanwhile.
//   cfg_* : letter_gap_weight write, always ready; write only while idle.
// Back end: a release is stored in the mark buffer while the back end is idle.
//   A letter end walks the mark buffer twice through its single read port before
//   out_valid rises.
// Reset: synchronous, active low; clears the queue, the timing state and the
//   mark count, and sets the weight to 4.
// ----------------------------------------------------------------------------
module morse_keying_decoder #(
  parameter int MAX_MARKS   = mkd_pkg::MAX_MARKS_DEF,
  parameter int LENGTH_BITS = mkd_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mkd_pkg::TIME_W-1:0]    in_edge_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mkd_pkg::CODE_W-1:0]    out_letter_code,
  output logic [mkd_pkg::TOTAL_W-1:0]   out_mark_total,
  output logic                          out_too_long,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mkd_pkg::WEIGHT_W-1:0]  cfg_data
);
  import mkd_pkg::*;

  localparam int QW = LENGTH_BITS + 2;

  logic          push;
  logic [QW-1:0] push_data;
  logic          full;
  logic          pop;
  logic          head_valid;
  logic [QW-1:0] head_data;

  // edge front end
  mkd_front #(
    .MAX_MARKS   (MAX_MARKS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_edge_time (in_edge_time),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_data    (push_data),
    .full         (full)
  );

  // command queue
  mkd_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // letter back end
  mkd_back #(
    .MAX_MARKS   (MAX_MARKS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (head_valid),
    .q_data          (head_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_letter_code (out_letter_code),
    .out_mark_total  (out_mark_total),
    .out_too_long    (out_too_long)
  );

endmodule
